// ===== sv/grid_dda_column_raycaster_assert.svh =====
// ----------------------------------------------------------------------------
// Raycaster assertion macros
// Shared concurrent assertion forms for the raycaster RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_DDA_COLUMN_RAYCASTER_ASSERT_SVH
`define GRID_DDA_COLUMN_RAYCASTER_ASSERT_SVH

// same-cycle implication
`define GDDA_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("gdda assertion failed");

// next-cycle implication
`define GDDA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("gdda assertion failed");

`endif

// ===== sv/gdda_pkg.sv =====
// ----------------------------------------------------------------------------
// Raycaster package
// Constants, register indexes and divider control types.
// ----------------------------------------------------------------------------
`default_nettype none

package gdda_pkg;

    localparam int MAX_SCREEN = 1024;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    localparam logic [7:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_SCREEN_HEIGHT = 8'd1;
    localparam logic [7:0] CFG_MAP_WIDTH     = 8'd2;
    localparam logic [7:0] CFG_MAP_HEIGHT    = 8'd3;

    localparam logic [31:0] COLOR_Y    = 32'h990000FF;
    localparam logic [31:0] COLOR_X    = 32'hDD0000FF;
    localparam logic [31:0] SAT32      = 32'hFFFFFFFF;
    localparam logic [31:0] NEAR_LIMIT = 32'd7;

    // divider: numerator, denominator and length counter widths
    localparam int DIV_NW = 45;
    localparam int DIV_DW = 44;
    localparam int DIV_LW = 6;

    // grid coordinate width, signed, covers one step outside the map
    localparam int GW = 9;
    // side distance accumulator width
    localparam int ACC_W = 48;

    typedef struct packed {
        logic              start;
        logic [DIV_LW-1:0] len;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/gdda_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Load and cast words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdda_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [11:0]        cell_index;
    logic               cell_wall;
    logic [9:0]         column;
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;

    modport source (output valid, opcode, cell_index, cell_wall, column, pos_x, pos_y,
                    dir_x, dir_y, plane_x, plane_y, input ready);
    modport sink (input valid, opcode, cell_index, cell_wall, column, pos_x, pos_y,
                  dir_x, dir_y, plane_x, plane_y, output ready);
endinterface

`default_nettype wire

// ===== sv/gdda_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// One column result word per cast.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdda_rsp_if;
    logic        valid;
    logic        ready;
    logic [9:0]  draw_start;
    logic [9:0]  draw_end;
    logic        side;
    logic        hit_wall;
    logic [31:0] wall_distance;
    logic [31:0] wall_color;

    modport source (output valid, draw_start, draw_end, side, hit_wall, wall_distance,
                    wall_color, input ready);
    modport sink (input valid, draw_start, draw_end, side, hit_wall, wall_distance,
                  wall_color, output ready);
endinterface

`default_nettype wire

// ===== sv/gdda_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Register write words: index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdda_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/gdda_div.sv =====
// ----------------------------------------------------------------------------
// Raycaster divider
// Restoring unsigned divider, one quotient bit per cycle, variable length.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_div
    import gdda_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_req_t          req,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output div_stat_t              stat,
    output logic [DIV_NW-1:0]      quo
);

    logic [DIV_LW-1:0] cnt_reg;
    logic              done_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW:0]   rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_NW-1:0] quo_reg;

    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[DIV_DW-1:0], num_reg[DIV_NW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= req.len;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DIV_LW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // align the numerator so its top bit enters first
            num_reg <= num << (DIV_LW'(DIV_NW) - req.len);
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[DIV_NW-2:0], 1'b0};
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

// ===== sv/gdda_map.sv =====
// ----------------------------------------------------------------------------
// Raycaster wall map
// One-bit grid store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_map #(
    parameter int MAP_DIM = 64,
    localparam int DEPTH  = MAP_DIM * MAP_DIM,
    localparam int AW     = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/grid_dda_column_raycaster.sv =====
// ----------------------------------------------------------------------------
// Grid DDA column raycaster
// A load word writes one wall bit into the grid map; a cast word walks a ray
// through the map and returns distance, side, hit flag, span and shade. The
// single shared divider produces one quotient bit per cycle for the camera
// coordinate (25 bits), the two step lengths (45 bits each) and the line
// height (27 bits), and each walk step is an update state followed by a map
// read state. The map has no reset and must be loaded before it is cast
// through. A finished result waits in the output register while the next
// word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_dda_column_raycaster_assert.svh"

module grid_dda_column_raycaster
    import gdda_pkg::*;
#(
    parameter int MAP_DIM = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gdda_req_if.sink   req,
    gdda_rsp_if.source rsp,
    gdda_cfg_if.sink   cfg
);

    localparam int AW = $clog2(MAP_DIM * MAP_DIM);
    localparam int LW = (AW > 15) ? AW : 15;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_CAM   = 14'b00000000000010,
        ST_RDX   = 14'b00000000000100,
        ST_RDY   = 14'b00000000001000,
        ST_DIVX  = 14'b00000000010000,
        ST_DIVY  = 14'b00000000100000,
        ST_SIDEX = 14'b00000001000000,
        ST_SIDEY = 14'b00000010000000,
        ST_STEP  = 14'b00000100000000,
        ST_PROBE = 14'b00001000000000,
        ST_LINE  = 14'b00010000000000,
        ST_LSET  = 14'b00100000000000,
        ST_LDIV  = 14'b01000000000000,
        ST_FIN   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [10:0] sw_reg, sh_reg;
    logic [6:0]  mw_reg, mh_reg;
    logic [10:0] sw_c, sh_c;
    logic [6:0]  mw_c, mh_c;

    logic [21:0]        px_reg, py_reg;
    logic signed [15:0] dirx_reg, diry_reg, plx_reg, ply_reg;
    logic signed [26:0] cam_reg;
    logic signed [43:0] rdx_reg, rdy_reg;
    logic [31:0]        dx_reg, dy_reg;
    logic [ACC_W-1:0]   sdx_reg, sdy_reg;
    logic signed [GW-1:0] gx_reg, gy_reg;
    logic               side_reg, hit_reg, first_reg;
    logic [31:0]        perp_reg;
    logic [9:0]         ds_reg, de_reg;

    logic               rsp_valid_reg;
    logic [9:0]         out_ds_reg, out_de_reg;
    logic               out_side_reg, out_hit_reg;
    logic [31:0]        out_dist_reg;

    logic cast_acc, load_acc, out_free;

    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [DIV_DW-1:0] div_den;
    logic [31:0]       quo_sat;

    logic signed [17:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [51:0] mul_p;
    logic signed [43:0] rd_new;
    logic signed [15:0] dir_sel;
    logic [43:0]        absx, absy;
    logic [16:0]        fx, fy;

    logic              map_wr_en, map_rd_en, map_rd_data;
    logic [AW-1:0]     map_rd_addr;
    logic [LW-1:0]     lin;
    logic              outside, take_x;
    logic [ACC_W-1:0]  perp_full;
    logic [26:0]       half, lh2, dend_full;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 11'd640;
            sh_reg <= 11'd480;
            mw_reg <= 7'd24;
            mh_reg <= 7'd24;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SCREEN_WIDTH:  sw_reg <= cfg.data;
                CFG_SCREEN_HEIGHT: sh_reg <= cfg.data;
                CFG_MAP_WIDTH:     mw_reg <= cfg.data[6:0];
                CFG_MAP_HEIGHT:    mh_reg <= cfg.data[6:0];
                default:           ;
            endcase
        end
    end

    assign sw_c = (sw_reg == '0) ? 11'd1 :
                  (32'(sw_reg) > MAX_SCREEN) ? 11'(MAX_SCREEN) : sw_reg;
    assign sh_c = (sh_reg == '0) ? 11'd1 :
                  (32'(sh_reg) > MAX_SCREEN) ? 11'(MAX_SCREEN) : sh_reg;
    assign mw_c = (mw_reg == '0) ? 7'd1 :
                  (32'(mw_reg) > MAP_DIM) ? 7'(MAP_DIM) : mw_reg;
    assign mh_c = (mh_reg == '0) ? 7'd1 :
                  (32'(mh_reg) > MAP_DIM) ? 7'(MAP_DIM) : mh_reg;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == ST_IDLE);
    assign cast_acc  = req.valid && req.ready && (req.opcode == OP_CAST);
    assign load_acc  = req.valid && req.ready && (req.opcode == OP_LOAD);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // ------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------
    assign fx = rdx_reg[43] ? {1'b0, px_reg[15:0]} : (17'h10000 - {1'b0, px_reg[15:0]});
    assign fy = rdy_reg[43] ? {1'b0, py_reg[15:0]} : (17'h10000 - {1'b0, py_reg[15:0]});

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        dir_sel = dirx_reg;
        case (state_reg)
            ST_RDX:
            begin
                mul_a   = {{2{plx_reg[15]}}, plx_reg};
                mul_b   = {{7{cam_reg[26]}}, cam_reg};
                dir_sel = dirx_reg;
            end
            ST_RDY:
            begin
                mul_a   = {{2{ply_reg[15]}}, ply_reg};
                mul_b   = {{7{cam_reg[26]}}, cam_reg};
                dir_sel = diry_reg;
            end
            ST_SIDEX:
            begin
                mul_a = {1'b0, fx};
                mul_b = {2'b00, dx_reg};
            end
            ST_SIDEY:
            begin
                mul_a = {1'b0, fy};
                mul_b = {2'b00, dy_reg};
            end
            default: ;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign rd_new = {{14{dir_sel[15]}}, dir_sel, 14'd0} + mul_p[43:0];

    assign absx = rdx_reg[43] ? 44'(-rdx_reg) : 44'(rdx_reg);
    assign absy = rdy_reg[43] ? 44'(-rdy_reg) : 44'(rdy_reg);

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.len   = '0;
        div_num       = '0;
        div_den       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                div_req.start = cast_acc;
                div_req.len   = DIV_LW'(25);
                div_num       = {20'd0, req.column, 15'd0};
                div_den       = {33'd0, sw_c};
            end
            ST_RDY:
            begin
                div_req.start = 1'b1;
                div_req.len   = DIV_LW'(DIV_NW);
                div_num       = {1'b1, 44'd0};
                div_den       = absx;
            end
            ST_DIVX:
            begin
                div_req.start = div_stat.done;
                div_req.len   = DIV_LW'(DIV_NW);
                div_num       = {1'b1, 44'd0};
                div_den       = absy;
            end
            ST_LSET:
            begin
                div_req.start = (perp_reg != '0);
                div_req.len   = DIV_LW'(27);
                div_num       = {18'd0, sh_c, 16'd0};
                div_den       = {12'd0, perp_reg};
            end
            default: ;
        endcase
    end

    gdda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign quo_sat = (|div_quo[DIV_NW-1:32]) ? SAT32 : div_quo[31:0];

    // ------------------------------------------------------------------
    // map store
    // ------------------------------------------------------------------
    assign map_wr_en = load_acc && (32'(req.cell_index) < 32'(MAP_DIM * MAP_DIM));

    assign outside = (gx_reg < 0) || (gx_reg >= $signed({2'b00, mw_c})) ||
                     (gy_reg < 0) || (gy_reg >= $signed({2'b00, mh_c}));
    assign lin = LW'(gy_reg[GW-2:0]) * LW'(mw_c) + LW'(gx_reg[GW-2:0]);
    assign map_rd_addr = lin[AW-1:0];
    assign map_rd_en   = (state_reg == ST_PROBE) && !outside;

    gdda_map #(
        .MAP_DIM (MAP_DIM)
    ) u_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (AW'(req.cell_index)),
        .wr_data (req.cell_wall),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    // ------------------------------------------------------------------
    // walk and span arithmetic
    // ------------------------------------------------------------------
    assign take_x    = sdx_reg < sdy_reg;
    assign perp_full = side_reg ? (sdy_reg - {16'd0, dy_reg}) : (sdx_reg - {16'd0, dx_reg});
    assign half      = {17'd0, sh_c[10:1]};
    assign lh2       = {1'b0, div_quo[26:1]};
    assign dend_full = half + lh2;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (cast_acc) state_next = ST_CAM;
            ST_CAM:   if (div_stat.done) state_next = ST_RDX;
            ST_RDX:   state_next = ST_RDY;
            ST_RDY:   state_next = ST_DIVX;
            ST_DIVX:  if (div_stat.done) state_next = ST_DIVY;
            ST_DIVY:  if (div_stat.done) state_next = ST_SIDEX;
            ST_SIDEX: state_next = ST_SIDEY;
            ST_SIDEY: state_next = ST_STEP;
            ST_STEP:  state_next = (!first_reg && map_rd_data) ? ST_LINE : ST_PROBE;
            ST_PROBE: state_next = outside ? ST_LINE : ST_STEP;
            ST_LINE:  state_next = ST_LSET;
            ST_LSET:  state_next = (perp_reg == '0) ? ST_FIN : ST_LDIV;
            ST_LDIV:  if (div_stat.done) state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (cast_acc)
                begin
                    px_reg   <= req.pos_x;
                    py_reg   <= req.pos_y;
                    dirx_reg <= req.dir_x;
                    diry_reg <= req.dir_y;
                    plx_reg  <= req.plane_x;
                    ply_reg  <= req.plane_y;
                    hit_reg  <= 1'b0;
                    side_reg <= 1'b0;
                    first_reg <= 1'b1;
                end
            end
            ST_CAM:
            begin
                if (div_stat.done)
                begin
                    cam_reg <= $signed({2'b00, div_quo[24:0]}) - 27'sd16384;
                end
            end
            ST_RDX: rdx_reg <= rd_new;
            ST_RDY: rdy_reg <= rd_new;
            ST_DIVX:
            begin
                if (div_stat.done)
                begin
                    dx_reg <= quo_sat;
                end
            end
            ST_DIVY:
            begin
                if (div_stat.done)
                begin
                    dy_reg <= quo_sat;
                end
            end
            ST_SIDEX:
            begin
                sdx_reg <= {15'd0, mul_p[48:16]};
                gx_reg  <= $signed({3'b000, px_reg[21:16]});
            end
            ST_SIDEY:
            begin
                sdy_reg <= {15'd0, mul_p[48:16]};
                gy_reg  <= $signed({3'b000, py_reg[21:16]});
            end
            ST_STEP:
            begin
                first_reg <= 1'b0;
                if (!first_reg && map_rd_data)
                begin
                    hit_reg <= 1'b1;
                end
                else if (take_x)
                begin
                    sdx_reg  <= sdx_reg + {16'd0, dx_reg};
                    gx_reg   <= rdx_reg[43] ? (gx_reg - 9'sd1) : (gx_reg + 9'sd1);
                    side_reg <= 1'b0;
                end
                else
                begin
                    sdy_reg  <= sdy_reg + {16'd0, dy_reg};
                    gy_reg   <= rdy_reg[43] ? (gy_reg - 9'sd1) : (gy_reg + 9'sd1);
                    side_reg <= 1'b1;
                end
            end
            ST_LINE:
            begin
                if (|perp_full[ACC_W-1:32])
                begin
                    perp_reg <= SAT32;
                end
                else if (perp_full[31:0] < NEAR_LIMIT)
                begin
                    perp_reg <= '0;
                end
                else
                begin
                    perp_reg <= perp_full[31:0];
                end
            end
            ST_LSET:
            begin
                // zero distance draws the full column
                if (perp_reg == '0)
                begin
                    ds_reg <= '0;
                    de_reg <= 10'(sh_c - 11'd1);
                end
            end
            ST_LDIV:
            begin
                if (div_stat.done)
                begin
                    ds_reg <= (lh2 > half) ? 10'd0 : 10'(half - lh2);
                    de_reg <= (dend_full >= {16'd0, sh_c}) ? 10'(sh_c - 11'd1)
                                                            : 10'(dend_full);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_ds_reg   <= ds_reg;
            out_de_reg   <= de_reg;
            out_side_reg <= side_reg;
            out_hit_reg  <= hit_reg;
            out_dist_reg <= perp_reg;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.draw_start    = out_ds_reg;
    assign rsp.draw_end      = out_de_reg;
    assign rsp.side          = out_side_reg;
    assign rsp.hit_wall      = out_hit_reg;
    assign rsp.wall_distance = out_dist_reg;
    assign rsp.wall_color    = out_side_reg ? COLOR_Y : COLOR_X;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `GDDA_ASSERT_IMPL(a_idle_div_free, clk, rst_n, state_reg == ST_IDLE, !div_stat.busy)
    `GDDA_ASSERT_NEXT(a_fin_loads_out, clk, rst_n, (state_reg == ST_FIN) && out_free, rsp_valid_reg)
    `GDDA_ASSERT_IMPL(a_read_in_map, clk, rst_n, map_rd_en, (gx_reg >= 0) && (gy_reg >= 0))

endmodule

`default_nettype wire

// ===== tb/grid_dda_column_raycaster_test.sv =====
// ----------------------------------------------------------------------------
// Grid DDA column raycaster testbench
// Fills the wall map, then sends directed and random cast words under several
// screen and map settings, with random idling on both channels. Each column
// result is checked field by field against an in-bench DDA predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_dda_column_raycaster_test;
    import gdda_pkg::*;

    // map cells loaded up front; map settings keep width times height within it
    localparam int FILL_CELLS = 576;

    typedef struct {
        logic               opcode;
        logic [11:0]        cell_index;
        logic               cell_wall;
        logic [9:0]         column;
        logic [21:0]        pos_x;
        logic [21:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
    } ray_word_t;

    typedef struct {
        logic [9:0]  draw_start;
        logic [9:0]  draw_end;
        logic        side;
        logic        hit_wall;
        logic [31:0] wall_distance;
        logic [31:0] wall_color;
    } column_t;

    logic clk;
    logic rst_n;

    gdda_req_if req ();
    gdda_rsp_if rsp ();
    gdda_cfg_if cfg ();

    grid_dda_column_raycaster dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // shadow registers and wall map
    logic [10:0] screen_w_sh;
    logic [10:0] screen_h_sh;
    logic [6:0]  map_w_sh;
    logic [6:0]  map_h_sh;
    logic        walls [0:4095];

    column_t pending_columns [$];
    int      errors;
    int      rx_hold;
    bit      quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("grid_dda_column_raycaster verification failed");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint recip_step(longint rd);
        longint mag;
        longint q;
        if (rd == 0)
            return 64'hFFFFFFFF;
        mag = (rd < 0) ? -rd : rd;
        q = (64'sd1 <<< 44) / mag;
        return (q > 64'hFFFFFFFF) ? 64'hFFFFFFFF : q;
    endfunction

    function automatic column_t cast_column(ray_word_t w);
        longint sw, sh, mw, mh, cam, rdx, rdy, gx, gy, sx, sy;
        longint dx, dy, sdx, sdy, fx, fy, perp, half, lh2, dstart, dend;
        bit side, hit;
        column_t c;
        sw = clamp(screen_w_sh, 1, MAX_SCREEN);
        sh = clamp(screen_h_sh, 1, MAX_SCREEN);
        mw = clamp(map_w_sh, 1, 64);
        mh = clamp(map_h_sh, 1, 64);
        cam = (2 * longint'(w.column) * 16384) / sw - 16384;
        rdx = longint'(w.dir_x) * 16384 + longint'(w.plane_x) * cam;
        rdy = longint'(w.dir_y) * 16384 + longint'(w.plane_y) * cam;
        dx = recip_step(rdx);
        dy = recip_step(rdy);
        gx = longint'(w.pos_x >> 16);
        gy = longint'(w.pos_y >> 16);
        fx = longint'(w.pos_x[15:0]);
        fy = longint'(w.pos_y[15:0]);
        if (rdx < 0)
        begin
            sx = -1;
            sdx = (fx * dx) >>> 16;
        end
        else
        begin
            sx = 1;
            sdx = ((65536 - fx) * dx) >>> 16;
        end
        if (rdy < 0)
        begin
            sy = -1;
            sdy = (fy * dy) >>> 16;
        end
        else
        begin
            sy = 1;
            sdy = ((65536 - fy) * dy) >>> 16;
        end
        side = 1'b0;
        hit = 1'b0;
        while (!hit)
        begin
            if (sdx < sdy)
            begin
                sdx += dx;
                gx += sx;
                side = 1'b0;
            end
            else
            begin
                sdy += dy;
                gy += sy;
                side = 1'b1;
            end
            if (gx < 0 || gx >= mw || gy < 0 || gy >= mh)
                break;
            if (walls[gy * mw + gx])
                hit = 1'b1;
        end
        perp = side ? sdy - dy : sdx - dx;
        if (perp > 64'hFFFFFFFF)
            perp = 64'hFFFFFFFF;
        if (perp < longint'(NEAR_LIMIT))
            perp = 0;
        half = sh / 2;
        if (perp == 0)
        begin
            dstart = 0;
            dend = sh - 1;
        end
        else
        begin
            lh2 = ((sh <<< 16) / perp) / 2;
            dstart = (lh2 > half) ? 0 : half - lh2;
            dend = half + lh2;
            if (dend >= sh)
                dend = sh - 1;
        end
        c.draw_start = dstart[9:0];
        c.draw_end = dend[9:0];
        c.side = side;
        c.hit_wall = hit;
        c.wall_distance = perp[31:0];
        c.wall_color = side ? COLOR_Y : COLOR_X;
        return c;
    endfunction

    function automatic ray_word_t load_word(int idx, bit wall);
        ray_word_t w;
        w = '{default: '0};
        w.opcode = OP_LOAD;
        w.cell_index = idx[11:0];
        w.cell_wall = wall;
        w.column = 10'($urandom);
        w.pos_x = 22'($urandom);
        w.pos_y = 22'($urandom);
        w.dir_x = 16'($urandom);
        w.dir_y = 16'($urandom);
        w.plane_x = 16'($urandom);
        w.plane_y = 16'($urandom);
        return w;
    endfunction

    // random cast word; when sane, well-formed: player inside the map, moderate direction and plane
    function automatic ray_word_t random_cast(bit sane);
        ray_word_t w;
        int mw, mh;
        mw = int'(clamp(map_w_sh, 1, 64));
        mh = int'(clamp(map_h_sh, 1, 64));
        w = load_word($urandom, $urandom);
        w.opcode = OP_CAST;
        if (sane)
        begin
            w.column = 10'($urandom_range(0, int'(clamp(screen_w_sh, 1, MAX_SCREEN)) - 1));
            w.pos_x = {6'($urandom_range(0, mw - 1)), 16'($urandom)};
            w.pos_y = {6'($urandom_range(0, mh - 1)), 16'($urandom)};
            w.dir_x = 16'(int'($urandom_range(0, 32768)) - 16384);
            w.dir_y = 16'(int'($urandom_range(0, 32768)) - 16384);
            w.plane_x = 16'(int'($urandom_range(0, 21000)) - 10500);
            w.plane_y = 16'(int'($urandom_range(0, 21000)) - 10500);
        end
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(ray_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 13)
        begin
            gap = $urandom_range(1, 4);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= w.opcode;
        req.cell_index <= w.cell_index;
        req.cell_wall <= w.cell_wall;
        req.column <= w.column;
        req.pos_x <= w.pos_x;
        req.pos_y <= w.pos_y;
        req.dir_x <= w.dir_x;
        req.dir_y <= w.dir_y;
        req.plane_x <= w.plane_x;
        req.plane_y <= w.plane_y;
        do @(posedge clk); while (!req.ready);
        if (w.opcode == OP_LOAD)
            walls[w.cell_index] = w.cell_wall;
        else
            pending_columns.push_back(cast_column(w));
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(negedge clk);
        while (pending_columns.size() > 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [10:0] value);
        drain();
        // let a trailing load settle
        repeat (16) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_SCREEN_WIDTH:  screen_w_sh = value;
            CFG_SCREEN_HEIGHT: screen_h_sh = value;
            CFG_MAP_WIDTH:     map_w_sh = value[6:0];
            CFG_MAP_HEIGHT:    map_h_sh = value[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // receiver: random stall, or a long counted hold-off
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= quiet || ($urandom_range(0, 99) >= 13);
        end
    end

    initial
    begin
        column_t exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (pending_columns.size() == 0)
                begin
                    $display("%0t: unexpected column word", $realtime);
                    errors++;
                end
                else
                begin
                    exp = pending_columns.pop_front();
                    if (rsp.draw_start !== exp.draw_start)
                    begin
                        $display("%0t: draw_start expected %0d actual %0d", $realtime,
                                 exp.draw_start, rsp.draw_start);
                        errors++;
                    end
                    if (rsp.draw_end !== exp.draw_end)
                    begin
                        $display("%0t: draw_end expected %0d actual %0d", $realtime,
                                 exp.draw_end, rsp.draw_end);
                        errors++;
                    end
                    if (rsp.side !== exp.side)
                    begin
                        $display("%0t: side expected %0d actual %0d", $realtime,
                                 exp.side, rsp.side);
                        errors++;
                    end
                    if (rsp.hit_wall !== exp.hit_wall)
                    begin
                        $display("%0t: hit_wall expected %0d actual %0d", $realtime,
                                 exp.hit_wall, rsp.hit_wall);
                        errors++;
                    end
                    if (rsp.wall_distance !== exp.wall_distance)
                    begin
                        $display("%0t: wall_distance expected %h actual %h", $realtime,
                                 exp.wall_distance, rsp.wall_distance);
                        errors++;
                    end
                    if (rsp.wall_color !== exp.wall_color)
                    begin
                        $display("%0t: wall_color expected %h actual %h", $realtime,
                                 exp.wall_color, rsp.wall_color);
                        errors++;
                    end
                end
            end
        end
    end

    // every cell a cast can reach is written before any cast can read it
    task automatic test_map_fill();
        for (int i = 0; i < FILL_CELLS; i++)
            send_word(load_word(i, $urandom_range(0, 7) == 0));
    endtask

    task automatic test_directed();
        ray_word_t w;
        int mw;
        mw = int'(clamp(map_w_sh, 1, 64));
        // wall right next to the player: zero distance gives the full span
        send_word(load_word(5 * mw + 6, 1'b1));
        w = random_cast(1'b1);
        w.pos_x = {6'd5, 16'hFFFF};
        w.pos_y = {6'd5, 16'h8000};
        w.dir_x = 16'sd16384;
        w.dir_y = 16'sd0;
        w.plane_x = 16'sd0;
        w.plane_y = 16'sd0;
        send_word(w);
        // axis-aligned rays, zero components saturate the step length
        w.dir_x = 16'sd0;
        w.dir_y = 16'sd16384;
        send_word(w);
        w.dir_y = 16'sd0;
        send_word(w);
        // extremes of direction and plane
        w.dir_x = -16'sd32768;
        w.dir_y = 16'sd32767;
        w.plane_x = 16'sd32767;
        w.plane_y = -16'sd32768;
        w.column = 10'd0;
        send_word(w);
        w.column = 10'd1023;
        send_word(w);
        // player outside the map and at the corners of the position range
        w.pos_x = 22'h3FFFFF;
        w.pos_y = 22'h3FFFFF;
        send_word(w);
        w.pos_x = 22'd0;
        w.pos_y = 22'd0;
        send_word(w);
        w.pos_x = {6'd40, 16'h1234};
        w.pos_y = {6'd2, 16'h0};
        w.dir_x = -16'sd16384;
        send_word(w);
        // empty cell loaded, then a ray cast toward the near map edge
        send_word(load_word(2 * mw + 1, 1'b0));
        w = random_cast(1'b1);
        w.pos_x = {6'd1, 16'h8000};
        w.pos_y = {6'd1, 16'h8000};
        w.dir_x = 16'sd0;
        w.dir_y = -16'sd16384;
        w.plane_x = 16'sd0;
        w.plane_y = 16'sd0;
        send_word(w);
        w.opcode = OP_CAST;
        w.dir_x = 16'sd11585;
        w.dir_y = 16'sd11585;
        send_word(w);
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 12)
                send_word(load_word($urandom, $urandom_range(0, 5) == 0));
            else
                send_word(random_cast($urandom_range(0, 99) < 85));
        end
    endtask

    task automatic test_settings();
        write_reg(CFG_SCREEN_WIDTH, 11'd1);
        write_reg(CFG_SCREEN_HEIGHT, 11'd1);
        write_reg(CFG_MAP_WIDTH, 11'd64);
        write_reg(CFG_MAP_HEIGHT, 11'd9);
        random_burst(60);
        write_reg(CFG_SCREEN_WIDTH, 11'd1024);
        write_reg(CFG_SCREEN_HEIGHT, 11'd1024);
        write_reg(CFG_MAP_WIDTH, 11'd1);
        write_reg(CFG_MAP_HEIGHT, 11'd1);
        random_burst(60);
        write_reg(CFG_SCREEN_WIDTH, 11'd0);
        write_reg(CFG_SCREEN_HEIGHT, 11'd2047);
        write_reg(CFG_MAP_WIDTH, 11'h7FF);
        write_reg(CFG_MAP_HEIGHT, 11'd0);
        random_burst(60);
        write_reg(CFG_SCREEN_WIDTH, 11'd320);
        write_reg(CFG_SCREEN_HEIGHT, 11'd200);
        write_reg(CFG_MAP_WIDTH, 11'd16);
        write_reg(CFG_MAP_HEIGHT, 11'd36);
        quiet = 1'b1;
        random_burst(80);
        quiet = 1'b0;
        random_burst(80);
    endtask

    task automatic test_backpressure();
        int mw_pick;
        rx_hold = 1500;
        random_burst(30);
        // pause until every column is back, then resume
        drain();
        random_burst(100);
        mw_pick = $urandom_range(1, 64);
        write_reg(CFG_SCREEN_WIDTH, 11'($urandom_range(1, 1024)));
        write_reg(CFG_SCREEN_HEIGHT, 11'($urandom_range(1, 1024)));
        write_reg(CFG_MAP_WIDTH, 11'(mw_pick));
        write_reg(CFG_MAP_HEIGHT, 11'($urandom_range(1, FILL_CELLS / mw_pick)));
        random_burst(100);
    endtask

    initial
    begin
        errors = 0;
        rx_hold = 0;
        quiet = 1'b0;
        screen_w_sh = 11'd640;
        screen_h_sh = 11'd480;
        map_w_sh = 7'd24;
        map_h_sh = 7'd24;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = OP_LOAD;
        req.cell_index = '0;
        req.cell_wall = 1'b0;
        req.column = '0;
        req.pos_x = '0;
        req.pos_y = '0;
        req.dir_x = '0;
        req.dir_y = '0;
        req.plane_x = '0;
        req.plane_y = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_map_fill();
        test_directed();
        random_burst(60);
        test_settings();
        test_backpressure();
        drain();
        repeat (600) @(negedge clk);
        if (errors == 0 && pending_columns.size() == 0)
            $display("grid_dda_column_raycaster verification clean");
        else
            $display("grid_dda_column_raycaster verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/gdda_pkg.sv
sv/gdda_req_if.sv
sv/gdda_rsp_if.sv
sv/gdda_cfg_if.sv
sv/gdda_div.sv
sv/gdda_map.sv
sv/grid_dda_column_raycaster.sv
tb/grid_dda_column_raycaster_test.sv
